/* hdl/pts_pkg.sv */
`default_nettype none
package pts_pkg;
    localparam int MaxEntries = 16;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);

    localparam logic [2:0] FN_CREATE   = 3'd0;
    localparam logic [2:0] FN_DISPATCH = 3'd1;
    localparam logic [2:0] FN_KILL     = 3'd2;
    localparam logic [2:0] FN_WAIT     = 3'd3;
    localparam logic [2:0] FN_RESUME   = 3'd4;
    localparam logic [2:0] FN_RESET    = 3'd5;
    localparam logic [2:0] FN_REPORT   = 3'd6;
    localparam logic [2:0] FN_RROBIN   = 3'd7;

    localparam logic [1:0] ST_READY      = 2'd0;
    localparam logic [1:0] ST_RUNNING    = 2'd1;
    localparam logic [1:0] ST_WAITING    = 2'd2;
    localparam logic [1:0] ST_TERMINATED = 2'd3;

    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_FULL     = 2'd1;
    localparam logic [1:0] RS_NOTFOUND = 2'd2;
    localparam logic [1:0] RS_EMPTY    = 2'd3;

    localparam logic [1:0] RM_PRIO  = 2'd1;
    localparam logic [1:0] RM_BURST = 2'd2;

    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  prio;
        logic [15:0] burst;
        logic [1:0]  st;
    } t_entry;
endpackage
`default_nettype wire

/* hdl/process_table_priority_scheduler.sv */
`default_nettype none
// Channel  | Direction | Handshake            | Payload
// input    | in        | i_valid / o_ready    | i_func i_task_id i_prio i_burst i_report_mode
// output   | out       | o_valid / i_ready    | o_status o_out_id o_start_time o_end_time o_last
//
// Dispatch, kill, wait and resume walk the table one entry per cycle.
// A sorted report does one exchange step a cycle through the single shared compare unit.
// Kill compacts one entry per cycle. Reports emit one row per cycle when taken.
// Reset clears the count and the id counter; the table contents are left as is.
// A pending result stalls the sequencer until it is taken.
module process_table_priority_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic [15:0] i_task_id,
    input  wire logic [3:0]  i_prio,
    input  wire logic [15:0] i_burst,
    input  wire logic [1:0]  i_report_mode,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_id,
    output logic [19:0]      o_start_time,
    output logic [19:0]      o_end_time,
    output logic             o_last
);
    localparam int IW = pts_pkg::IdxW;
    localparam int CW = pts_pkg::CntW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_SORT = 3'd3;
    localparam logic [2:0] S_ROWS = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    pts_pkg::t_entry r_tab [pts_pkg::MaxEntries];
    logic [2:0]  r_state;
    logic [CW-1:0] r_cnt;
    logic [15:0] r_next_id;
    logic [2:0]  r_func;
    logic [15:0] r_tid;
    logic [1:0]  r_mode;
    logic [CW-1:0] r_i, r_j;
    logic        r_found;
    logic [IW-1:0] r_idx;
    logic [19:0] r_t;
    logic        r_ov;
    logic [1:0]  r_ost;
    logic [15:0] r_oid;
    logic [19:0] r_ostart, r_oend;
    logic        r_olast;

    pts_pkg::t_entry w_a, w_b, w_best;
    logic w_lt, w_gtb, w_bgt, w_ideq, w_sw;
    logic [19:0] w_e;

    assign w_a    = r_tab[r_i[IW-1:0]];
    assign w_b    = r_tab[r_j[IW-1:0]];
    assign w_best = r_tab[r_idx];

    // In the scan, operand a is the best candidate so far and b is the scanned entry.
    pts_cmp u_cmp (
        .i_a(r_state == S_SCAN ? w_best : w_a), .i_b(w_b), .i_id(r_tid),
        .o_a_lt_b_prio(w_lt), .o_a_gt_b_burst(w_gtb),
        .o_b_gt_a_prio(w_bgt), .o_id_eq(w_ideq)
    );
    assign w_sw = (r_mode == pts_pkg::RM_PRIO) ? w_lt : w_gtb;
    assign w_e  = r_t + {4'd0, w_a.burst};

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_out_id = r_oid;
    assign o_start_time = r_ostart;
    assign o_end_time = r_oend;
    assign o_last = r_olast;

    wire w_osl = !r_ov || i_ready;

    // A new result is loaded when a report row or a final result is ready to leave.
    wire w_load = w_osl && (r_state == S_DONE ||
                            (r_state == S_ROWS && r_func != pts_pkg::FN_RROBIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_next_id <= 16'd1;
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_load || (r_ov && !i_ready);
            case (r_state)
            S_IDLE: begin
                if (i_valid && !r_ov) begin
                    r_func <= i_func; r_tid <= i_task_id; r_mode <= i_report_mode;
                    r_i <= '0; r_j <= '0; r_found <= 1'b0; r_t <= '0;
                    r_ost <= pts_pkg::RS_OK; r_oid <= '0; r_ostart <= '0;
                    r_oend <= '0; r_olast <= 1'b1;
                    r_state <= S_SCAN;
                    case (i_func)
                    pts_pkg::FN_CREATE: begin
                        r_state <= S_DONE;
                        if (r_cnt == CW'(pts_pkg::MaxEntries)) begin
                            r_ost <= pts_pkg::RS_FULL;
                        end else begin
                            r_tab[r_cnt[IW-1:0]] <= '{r_next_id, i_prio, i_burst,
                                                     pts_pkg::ST_READY};
                            r_oid <= r_next_id;
                            r_cnt <= r_cnt + 1'b1;
                            r_next_id <= r_next_id + 16'd1;
                        end
                    end
                    pts_pkg::FN_RESET: begin
                        r_cnt <= '0; r_next_id <= 16'd1; r_state <= S_DONE;
                    end
                    pts_pkg::FN_REPORT, pts_pkg::FN_RROBIN: begin
                        if (r_cnt == '0) begin
                            r_ost <= pts_pkg::RS_EMPTY; r_state <= S_DONE;
                        end else if (i_func == pts_pkg::FN_REPORT &&
                                     (i_report_mode inside {pts_pkg::RM_PRIO,
                                                            pts_pkg::RM_BURST})) begin
                            r_j <= CW'(1); r_state <= S_SORT;
                        end else begin
                            r_state <= S_ROWS;
                        end
                    end
                    default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // r_j walks the table for dispatch, kill, wait and resume.
                if (r_j == r_cnt) begin
                    r_state <= S_DONE;
                    if (!r_found) begin
                        r_ost <= (r_func == pts_pkg::FN_DISPATCH) ? pts_pkg::RS_EMPTY
                                                                   : pts_pkg::RS_NOTFOUND;
                    end else begin
                        case (r_func)
                        pts_pkg::FN_DISPATCH: begin
                            r_tab[r_idx].st <= pts_pkg::ST_RUNNING;
                            r_oid <= w_best.id;
                        end
                        pts_pkg::FN_WAIT: begin
                            r_tab[r_idx].st <= pts_pkg::ST_WAITING; r_oid <= r_tid;
                        end
                        pts_pkg::FN_RESUME: begin
                            r_tab[r_idx].st <= pts_pkg::ST_READY; r_oid <= r_tid;
                        end
                        default: begin
                            r_oid <= r_tid; r_i <= {1'b0, r_idx};
                            r_state <= S_SHIFT;
                        end
                        endcase
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                    if (r_func == pts_pkg::FN_DISPATCH) begin
                        if (w_b.st == pts_pkg::ST_READY && (!r_found || w_bgt)) begin
                            r_found <= 1'b1; r_idx <= r_j[IW-1:0];
                        end
                    end else if (!r_found && w_ideq &&
                                 (r_func != pts_pkg::FN_RESUME ||
                                  w_b.st == pts_pkg::ST_WAITING)) begin
                        r_found <= 1'b1; r_idx <= r_j[IW-1:0];
                    end
                end
            end
            S_SHIFT: begin
                if (r_i + 1'b1 >= r_cnt) begin
                    r_cnt <= r_cnt - 1'b1; r_state <= S_DONE;
                end else begin
                    r_tab[r_i[IW-1:0]] <= r_tab[IW'(r_i + 1'b1)];
                    r_i <= r_i + 1'b1;
                end
            end
            S_SORT: begin
                if (r_i + 1'b1 >= r_cnt) begin
                    r_i <= '0; r_state <= S_ROWS;
                end else begin
                    if (w_sw) begin
                        r_tab[r_i[IW-1:0]] <= w_b;
                        r_tab[r_j[IW-1:0]] <= w_a;
                    end
                    if (r_j + 1'b1 >= r_cnt) begin
                        r_i <= r_i + 1'b1; r_j <= r_i + 2'd2;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            S_ROWS: begin
                if (r_func == pts_pkg::FN_RROBIN) begin
                    r_tab[r_i[IW-1:0]].st <= pts_pkg::ST_TERMINATED;
                    r_t <= w_e; r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_cnt) begin
                        r_oend <= w_e; r_state <= S_DONE;
                    end
                end else if (w_osl) begin
                    r_ost <= pts_pkg::RS_OK; r_oid <= w_a.id;
                    r_ostart <= r_t; r_oend <= w_e;
                    r_olast <= (r_i + 1'b1 == r_cnt);
                    r_t <= w_e; r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_cnt) r_state <= S_IDLE;
                end
            end
            S_DONE: begin
                if (w_osl) begin
                    r_state <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(pts_pkg::MaxEntries)) else $error("count above depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_kill_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_i + 1'b1 >= r_cnt) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("kill did not shrink table");
endmodule
`default_nettype wire

/* hdl/pts_cmp.sv */
`default_nettype none
// Shared compare unit: the priority, burst and id comparisons of the sequencer go through here.
module pts_cmp (
    input  wire pts_pkg::t_entry i_a,
    input  wire pts_pkg::t_entry i_b,
    input  wire logic [15:0]     i_id,
    output logic                 o_a_lt_b_prio,
    output logic                 o_a_gt_b_burst,
    output logic                 o_b_gt_a_prio,
    output logic                 o_id_eq
);
    assign o_a_lt_b_prio  = i_a.prio < i_b.prio;
    assign o_a_gt_b_burst = i_a.burst > i_b.burst;
    assign o_b_gt_a_prio  = i_b.prio > i_a.prio;
    assign o_id_eq        = i_b.id == i_id;
endmodule
`default_nettype wire
